@@ src/sha512_pkg.sv @@
// Types and constants shared by the SHA-512 engine.
`default_nettype none
package sha512_pkg;

    typedef struct packed {
        logic [63:0] data_word;
        logic [3:0]  byte_count;
        logic        last_chunk;
    } msg_item_t;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } dig_item_t;

    // eight 64-bit words, index 0 first (a .. h, or H0 .. H7)
    typedef logic [0:7][63:0] word8_t;

    localparam word8_t INIT_HASH = {
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
        64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [0:79][63:0] ROUND_K = {
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

endpackage
`default_nettype wire

@@ src/sha512_round.sv @@
// One SHA-512 round and one message schedule step, combinational.
`default_nettype none
module sha512_round
    import sha512_pkg::*;
(
    input  wire word8_t        work,
    input  wire logic [1023:0] sched,
    input  wire logic [63:0]   round_k,
    output word8_t             work_next,
    output logic [63:0]        w_new
);
    logic [63:0] a, e, w0, w1, w9, w14;
    logic [63:0] sig0, sig1, ch, maj, t1, t2, ss0, ss1;

    // schedule words, word 0 in the top bits
    assign w0  = sched[1023:960];
    assign w1  = sched[959:896];
    assign w9  = sched[447:384];
    assign w14 = sched[127:64];

    assign ss0   = {w1[0], w1[63:1]} ^ {w1[7:0], w1[63:8]} ^ (w1 >> 7);
    assign ss1   = {w14[18:0], w14[63:19]} ^ {w14[60:0], w14[63:61]} ^ (w14 >> 6);
    assign w_new = ss1 + w9 + ss0 + w0;

    // round function
    assign a    = work[0];
    assign e    = work[4];
    assign sig1 = {e[13:0], e[63:14]} ^ {e[17:0], e[63:18]} ^ {e[40:0], e[63:41]};
    assign sig0 = {a[27:0], a[63:28]} ^ {a[33:0], a[63:34]} ^ {a[38:0], a[63:39]};
    assign ch   = (e & work[5]) ^ (~e & work[6]);
    assign maj  = (a & work[1]) ^ (a & work[2]) ^ (work[1] & work[2]);
    assign t1   = work[7] + sig1 + ch + round_k + w0;
    assign t2   = sig0 + maj;

    always_comb
    begin
        work_next[0] = t1 + t2;
        work_next[1] = work[0];
        work_next[2] = work[1];
        work_next[3] = work[2];
        work_next[4] = work[3] + t1;
        work_next[5] = work[4];
        work_next[6] = work[5];
        work_next[7] = work[6];
    end
endmodule
`default_nettype wire

@@ src/sha512_hash_top.sv @@
// SHA-512 engine top level: byte packing, padding, round sequencer, digest output.
// Each item carries up to eight message bytes. A chunk that does not complete
// a block is accepted, appended, and followed by the return to idle. A chunk
// that completes a 128-byte block also runs the compression on the shared
// round unit, then the hash update. The last chunk adds padding (plus one more
// compression when more than 111 bytes are pending), the final compression,
// and then eight digest items, word 0 first, one per cycle unless stalled.
// The engine takes no new item until the digest has been fully delivered.
`default_nettype none
module sha512_hash_top
    import sha512_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      msg_valid,
    output logic           msg_stall,
    input  wire msg_item_t msg_item,
    output logic           dig_valid,
    input  wire logic      dig_stall,
    output dig_item_t      dig_item
);
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_ABSORB = 4'd1;
    localparam logic [3:0] ST_PAD    = 4'd2;
    localparam logic [3:0] ST_PADZ   = 4'd3;
    localparam logic [3:0] ST_LENH   = 4'd4;
    localparam logic [3:0] ST_LENL   = 4'd5;
    localparam logic [3:0] ST_ROUND  = 4'd6;
    localparam logic [3:0] ST_HADD   = 4'd7;
    localparam logic [3:0] ST_OUT    = 4'd8;

    logic [3:0]    state_reg, state_next, ret_reg, ret_next;
    logic [6:0]    fill_reg, fill_next;
    logic [63:0]   data_reg, data_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic          last_reg, last_next;
    logic [1023:0] blk_reg, blk_next;
    word8_t        hash_reg, hash_next, work_reg, work_next;
    logic [6:0]    rnd_reg, rnd_next;
    logic [2:0]    idx_reg, idx_next;
    logic [127:0]  bits_reg, bits_next;

    logic [63:0]   app_src;
    logic [3:0]    app_k;
    logic [1087:0] app_wide;
    logic [7:0]    app_sum, room, gap;
    word8_t        rnd_out;
    logic [63:0]   w_new;

    sha512_round u_round (
        .work      (work_reg),
        .sched     (blk_reg),
        .round_k   (ROUND_K[rnd_reg]),
        .work_next (rnd_out),
        .w_new     (w_new)
    );

    // byte append: shift block left by k bytes, top k bytes of source enter
    assign app_wide = {blk_reg, app_src} << {app_k, 3'b000};
    assign app_sum  = {1'b0, fill_reg} + {4'd0, app_k};
    assign room     = 8'd128 - {1'b0, fill_reg};
    assign gap      = ((fill_reg > 7'd112) ? 8'd128 : 8'd112) - {1'b0, fill_reg};

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        fill_next  = fill_reg;
        data_next  = data_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        blk_next   = blk_reg;
        hash_next  = hash_reg;
        work_next  = work_reg;
        rnd_next   = rnd_reg;
        idx_next   = idx_reg;
        bits_next  = bits_reg;
        app_src    = data_reg;
        app_k      = 4'd0;
        case (state_reg)
            ST_IDLE:
            begin
                if (msg_valid)
                begin
                    data_next  = msg_item.data_word;
                    cnt_next   = (msg_item.byte_count > 4'd8) ? 4'd8 : msg_item.byte_count;
                    last_next  = msg_item.last_chunk;
                    state_next = ST_ABSORB;
                end
            end
            ST_ABSORB:
            begin
                if (cnt_reg == 4'd0)
                begin
                    if (last_reg)
                    begin
                        bits_next  = bits_reg + {118'd0, fill_reg, 3'b000};
                        state_next = ST_PAD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    app_k     = ({4'd0, cnt_reg} < room) ? cnt_reg : room[3:0];
                    blk_next  = app_wide[1087:64];
                    fill_next = app_sum[6:0];
                    data_next = data_reg << {app_k, 3'b000};
                    cnt_next  = cnt_reg - app_k;
                    if (app_sum[7])
                    begin
                        bits_next  = bits_reg + 128'd1024;
                        work_next  = hash_reg;
                        rnd_next   = 7'd0;
                        ret_next   = ST_ABSORB;
                        state_next = ST_ROUND;
                    end
                end
            end
            ST_PAD:
            begin
                app_src   = {8'h80, 56'd0};
                app_k     = 4'd1;
                blk_next  = app_wide[1087:64];
                fill_next = app_sum[6:0];
                if (app_sum[7])
                begin
                    work_next  = hash_reg;
                    rnd_next   = 7'd0;
                    ret_next   = ST_PADZ;
                    state_next = ST_ROUND;
                end
                else
                begin
                    state_next = ST_PADZ;
                end
            end
            ST_PADZ:
            begin
                if (fill_reg == 7'd112)
                begin
                    state_next = ST_LENH;
                end
                else
                begin
                    app_src   = 64'd0;
                    app_k     = (gap > 8'd8) ? 4'd8 : gap[3:0];
                    blk_next  = app_wide[1087:64];
                    fill_next = app_sum[6:0];
                    if (app_sum[7])
                    begin
                        work_next  = hash_reg;
                        rnd_next   = 7'd0;
                        ret_next   = ST_PADZ;
                        state_next = ST_ROUND;
                    end
                end
            end
            ST_LENH:
            begin
                app_src    = bits_reg[127:64];
                app_k      = 4'd8;
                blk_next   = app_wide[1087:64];
                fill_next  = app_sum[6:0];
                state_next = ST_LENL;
            end
            ST_LENL:
            begin
                app_src    = bits_reg[63:0];
                app_k      = 4'd8;
                blk_next   = app_wide[1087:64];
                fill_next  = app_sum[6:0];
                work_next  = hash_reg;
                rnd_next   = 7'd0;
                ret_next   = ST_OUT;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                work_next = rnd_out;
                blk_next  = {blk_reg[959:0], w_new};
                rnd_next  = rnd_reg + 7'd1;
                if (rnd_reg == 7'd79)
                begin
                    state_next = ST_HADD;
                end
            end
            ST_HADD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_next[i] = hash_reg[i] + work_reg[i];
                end
                idx_next   = 3'd0;
                state_next = ret_reg;
            end
            ST_OUT:
            begin
                if (!dig_stall)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        hash_next  = INIT_HASH;
                        bits_next  = 128'd0;
                        fill_next  = 7'd0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            fill_reg  <= 7'd0;
            cnt_reg   <= 4'd0;
            last_reg  <= 1'b0;
            hash_reg  <= INIT_HASH;
            rnd_reg   <= 7'd0;
            idx_reg   <= 3'd0;
            bits_reg  <= 128'd0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            fill_reg  <= fill_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
            hash_reg  <= hash_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
            bits_reg  <= bits_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        blk_reg  <= blk_next;
        work_reg <= work_next;
    end

    // handshake and digest output
    assign msg_stall            = (state_reg != ST_IDLE);
    assign dig_valid            = (state_reg == ST_OUT);
    assign dig_item.digest_word = hash_reg[idx_reg];
    assign dig_item.word_index  = idx_reg;
    assign dig_item.last_word   = (idx_reg == 3'd7);
endmodule
`default_nettype wire
